// File: rtl/triple_buffered_periodic_frame_tx_macros.svh
// ----------------------------------------------------------------------------
// Triple-buffered frame transmitter assertion macros
// Concurrent assertion helpers shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef TRIPLE_BUFFERED_PERIODIC_FRAME_TX_MACROS_SVH
`define TRIPLE_BUFFERED_PERIODIC_FRAME_TX_MACROS_SVH

`ifndef ASSERT_OFF
`define TBPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbpf assertion failed");
`define TBPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbpf assertion failed");
`else
`define TBPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TBPF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/tbpf_pkg.sv
// ----------------------------------------------------------------------------
// Triple-buffered frame transmitter package
// Sizes, action and result codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpf_pkg;

    localparam int FRAME_BYTES  = 64;
    localparam int BUFFER_COUNT = 3;
    localparam int CNT_W        = 32;
    localparam int SLOT_W       = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_PUBLISH = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_PUB    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_SKIP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

endpackage

`default_nettype wire

// File: rtl/tbpf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/triple_buffered_periodic_frame_tx.sv
// Load, disabled tick: no result; next item may follow at once.
// Publish, rejected publish, skipped tick: one result, valid in the next cycle.
// Sending tick: one byte per cycle while output is ready, from the single frame store
// read port and the output register; input is not ready until the last byte is handed
// over. Reset (synchronous) clears counters, lengths, generations and control; frame
// store contents are left as they are and never read before being written.
// ----------------------------------------------------------------------------
// Triple-buffered periodic frame transmitter
// Three frame buffers in one store, two used; publish swaps active, ticks stream it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triple_buffered_periodic_frame_tx_macros.svh"

module triple_buffered_periodic_frame_tx #(
    parameter int FRAME_BYTES = tbpf_pkg::FRAME_BYTES
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [1:0]                      i_action,
    input  wire  [7:0]                      i_data_byte,
    input  wire                             i_link_busy,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_tx_byte,
    output logic                            o_last,
    output logic [tbpf_pkg::CNT_W-1:0]      o_sent_total,
    output logic [tbpf_pkg::CNT_W-1:0]      o_skipped_total,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [tbpf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire                             i_cfg_data
);

    localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
    localparam int STORE_DEPTH = tbpf_pkg::BUFFER_COUNT * FRAME_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CW          = tbpf_pkg::CNT_W;
    localparam int SW          = tbpf_pkg::SLOT_W;

    tbpf_pkg::t_state r_state, n_state;

    logic             r_repeat_mode;
    logic             r_enable;
    logic [LEN_W-1:0] r_frame_len [tbpf_pkg::BUFFER_COUNT];
    logic [CW-1:0]    r_frame_gen [tbpf_pkg::BUFFER_COUNT];
    logic [CW-1:0]    r_gen_ctr;
    logic [CW-1:0]    r_last_gen;
    logic [SW-1:0]    r_active;
    logic [LEN_W-1:0] r_fill_count;
    logic             r_fill_overflow;
    logic [CW-1:0]    r_sent_ctr;
    logic [CW-1:0]    r_skip_ctr;
    logic [LEN_W-1:0] r_idx;
    logic             r_out_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_tx_byte;
    logic             r_last;

    logic             n_out_valid;
    logic [1:0]       n_kind;
    logic [7:0]       n_tx_byte;
    logic             n_last;
    logic             out_load;

    logic             in_fire;
    logic             out_free;
    logic             out_fire;
    logic [SW-1:0]    fill_slot;
    logic [LEN_W-1:0] cur_len;
    logic [CW-1:0]    cur_gen;
    logic             tick_on;
    logic             tick_send;
    logic             start_send;
    logic             stream_last;
    logic [LEN_W-1:0] idx_inc;
    logic             fill_room;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    assign out_free  = !r_out_valid || i_out_ready;
    assign out_fire  = r_out_valid && i_out_ready;
    assign in_fire   = i_in_valid && o_in_ready;
    assign fill_slot = (r_active == SW'(0)) ? SW'(1) : SW'(0);
    assign cur_len   = r_frame_len[r_active];
    assign cur_gen   = r_frame_gen[r_active];
    assign fill_room = r_fill_count < LEN_W'(FRAME_BYTES);
    assign idx_inc   = r_idx + LEN_W'(1);

    assign stream_last = idx_inc == cur_len;
    assign tick_on     = in_fire && (i_action == tbpf_pkg::ACT_TICK) && r_enable;
    assign tick_send   = (cur_len != '0) && !i_link_busy
                         && (r_repeat_mode || (cur_gen != r_last_gen));
    assign start_send  = tick_on && tick_send;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tbpf_pkg::ST_IDLE: begin
                if (start_send) begin
                    n_state = tbpf_pkg::ST_SEND;
                end
            end
            tbpf_pkg::ST_SEND: begin
                if (out_free && stream_last) begin
                    n_state = tbpf_pkg::ST_IDLE;
                end
            end
            default: n_state = tbpf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = ADDR_W'(r_active) * ADDR_W'(FRAME_BYTES);
        case (r_state)
            tbpf_pkg::ST_IDLE: begin
                o_in_ready = out_free;
                ram_re     = start_send;
            end
            tbpf_pkg::ST_SEND: begin
                ram_re    = out_free && !stream_last;
                ram_raddr = ADDR_W'(r_active) * ADDR_W'(FRAME_BYTES) + ADDR_W'(idx_inc);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign ram_we    = in_fire && (i_action == tbpf_pkg::ACT_LOAD) && fill_room;
    assign ram_waddr = ADDR_W'(fill_slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(r_fill_count);

    tbpf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        out_load  = 1'b0;
        n_kind    = r_kind;
        n_tx_byte = r_tx_byte;
        n_last    = r_last;
        if (r_state == tbpf_pkg::ST_SEND) begin
            if (out_free) begin
                out_load  = 1'b1;
                n_kind    = tbpf_pkg::KIND_BYTE;
                n_tx_byte = ram_rdata;
                n_last    = stream_last;
            end
        end else if (in_fire && (i_action == tbpf_pkg::ACT_PUBLISH)) begin
            out_load  = 1'b1;
            n_kind    = r_fill_overflow ? tbpf_pkg::KIND_REJECT : tbpf_pkg::KIND_PUB;
            n_tx_byte = 8'd0;
            n_last    = 1'b1;
        end else if (tick_on && !tick_send) begin
            out_load  = 1'b1;
            n_kind    = tbpf_pkg::KIND_SKIP;
            n_tx_byte = 8'd0;
            n_last    = 1'b1;
        end
        n_out_valid = out_load || (r_out_valid && !out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tbpf_pkg::ST_IDLE;
            r_repeat_mode   <= 1'b1;
            r_enable        <= 1'b0;
            r_frame_len     <= '{default: '0};
            r_frame_gen     <= '{default: '0};
            r_gen_ctr       <= '0;
            r_last_gen      <= '1;
            r_active        <= '0;
            r_fill_count    <= '0;
            r_fill_overflow <= 1'b0;
            r_sent_ctr      <= '0;
            r_skip_ctr      <= '0;
            r_idx           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tbpf_pkg::CFG_REPEAT_MODE: r_repeat_mode <= i_cfg_data;
                    tbpf_pkg::CFG_ENABLE:      r_enable      <= i_cfg_data;
                    default:                   r_enable      <= r_enable;
                endcase
            end
            if (in_fire && (i_action == tbpf_pkg::ACT_LOAD)) begin
                if (fill_room) begin
                    r_fill_count <= r_fill_count + LEN_W'(1);
                end else begin
                    r_fill_overflow <= 1'b1;
                end
            end
            if (in_fire && (i_action == tbpf_pkg::ACT_PUBLISH)) begin
                r_fill_count    <= '0;
                r_fill_overflow <= 1'b0;
                if (!r_fill_overflow) begin
                    r_frame_len[fill_slot] <= r_fill_count;
                    r_frame_gen[fill_slot] <= r_gen_ctr + CW'(1);
                    r_gen_ctr              <= r_gen_ctr + CW'(1);
                    r_active               <= fill_slot;
                end
            end
            if (tick_on) begin
                if (tick_send) begin
                    r_sent_ctr <= r_sent_ctr + CW'(1);
                    if (!r_repeat_mode) begin
                        r_last_gen <= cur_gen;
                    end
                end else begin
                    r_skip_ctr <= r_skip_ctr + CW'(1);
                end
            end
            if (start_send) begin
                r_idx <= '0;
            end else if ((r_state == tbpf_pkg::ST_SEND) && out_free && !stream_last) begin
                r_idx <= idx_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_tx_byte <= n_tx_byte;
        r_last    <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_tx_byte       = r_tx_byte;
    assign o_last          = r_last;
    assign o_sent_total    = r_sent_ctr;
    assign o_skipped_total = r_skip_ctr;
    assign o_cfg_ready     = 1'b1;

    `TBPF_ASSERT_NXT(a_stream_end, i_clk, i_rst_n, (r_state == tbpf_pkg::ST_SEND) && out_free && stream_last, (r_state == tbpf_pkg::ST_IDLE) && o_out_valid && o_last)
    `TBPF_ASSERT_IMP(a_byte_in_send, i_clk, i_rst_n, o_out_valid && (o_kind == tbpf_pkg::KIND_BYTE) && !o_last, r_state == tbpf_pkg::ST_SEND)
    `TBPF_ASSERT_IMP(a_overflow_full, i_clk, i_rst_n, r_fill_overflow, r_fill_count == LEN_W'(FRAME_BYTES))

endmodule

`default_nettype wire

// File: test/triple_buffered_periodic_frame_tx_test.sv
// ----------------------------------------------------------------------------
// Triple-buffered periodic frame transmitter testbench
// Feeds loads, publishes and timer ticks through the valid/ready input channel
// and writes the mode and enable registers between phases. A local model of
// the buffers, generations and counters predicts every result beat, and the
// monitor compares each beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_buffered_periodic_frame_tx_test;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         SINK_HOLD      = 300;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASES         = 6;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data;
        logic       busy;
    } t_frame_cmd;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [7:0]                 tx_byte;
        logic                       last;
        logic [tbpf_pkg::CNT_W-1:0] sent;
        logic [tbpf_pkg::CNT_W-1:0] skipped;
    } t_frame_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           o_in_ready;
    logic [1:0]                     in_action = '0;
    logic [7:0]                     in_data = '0;
    logic                           in_busy = 1'b0;
    logic                           o_out_valid;
    logic                           out_ready = 1'b0;
    logic [1:0]                     o_kind;
    logic [7:0]                     o_tx_byte;
    logic                           o_last;
    logic [tbpf_pkg::CNT_W-1:0]     o_sent_total;
    logic [tbpf_pkg::CNT_W-1:0]     o_skipped_total;
    logic                           cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [tbpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic                           cfg_data = 1'b0;

    logic in_beat = 1'b0;
    logic cfg_beat = 1'b0;

    t_frame_cmd    cmd_queue[$];
    t_frame_result tx_results_due[$];

    // model state
    logic [7:0]                 frame_bytes[tbpf_pkg::BUFFER_COUNT*tbpf_pkg::FRAME_BYTES];
    logic [6:0]                 frame_len[tbpf_pkg::BUFFER_COUNT];
    logic [tbpf_pkg::CNT_W-1:0] frame_gen[tbpf_pkg::BUFFER_COUNT];
    logic [tbpf_pkg::CNT_W-1:0] gen_count = '0;
    logic [tbpf_pkg::CNT_W-1:0] last_sent_gen = '1;
    logic [1:0]                 active_buf = '0;
    logic [6:0]                 fill_level = '0;
    logic                       fill_overrun = 1'b0;
    logic [tbpf_pkg::CNT_W-1:0] sent_tally = '0;
    logic [tbpf_pkg::CNT_W-1:0] skip_count = '0;
    logic                       mode_repeat = 1'b1;
    logic                       mode_enable = 1'b0;

    int  mismatch_count = 0;
    int  items_counted = 0;
    bit  calm_src = 1'b0;
    bit  calm_sink = 1'b0;
    int  hold_req = 0;
    int  hold_ack = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;

    triple_buffered_periodic_frame_tx u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (in_action),
        .i_data_byte     (in_data),
        .i_link_busy     (in_busy),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_sent_total    (o_sent_total),
        .o_skipped_total (o_skipped_total),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < tbpf_pkg::BUFFER_COUNT; i++) begin
            frame_len[i] = '0;
            frame_gen[i] = '0;
        end
        for (int i = 0; i < tbpf_pkg::BUFFER_COUNT*tbpf_pkg::FRAME_BYTES; i++) begin
            frame_bytes[i] = '0;
        end
    end

    task automatic note_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_result(input logic [1:0] kind, input logic [7:0] b, input logic last);
        tx_results_due.push_back('{kind, b, last, sent_tally, skip_count});
    endtask

    task automatic apply_frame_cmd(input t_frame_cmd cmd);
        logic [1:0]                 fill_buf;
        logic [6:0]                 len;
        logic [tbpf_pkg::CNT_W-1:0] gen;
        fill_buf = (active_buf == 2'd0) ? 2'd1 : 2'd0;
        case (cmd.action)
            tbpf_pkg::ACT_LOAD: begin
                if (fill_level < tbpf_pkg::FRAME_BYTES) begin
                    frame_bytes[fill_buf*tbpf_pkg::FRAME_BYTES + fill_level] = cmd.data;
                    fill_level++;
                end else begin
                    fill_overrun = 1'b1;
                end
            end
            tbpf_pkg::ACT_PUBLISH: begin
                if (fill_overrun) begin
                    fill_overrun = 1'b0;
                    fill_level = '0;
                    push_result(tbpf_pkg::KIND_REJECT, 8'd0, 1'b1);
                end else begin
                    frame_len[fill_buf] = fill_level;
                    gen_count++;
                    frame_gen[fill_buf] = gen_count;
                    active_buf = fill_buf;
                    fill_level = '0;
                    push_result(tbpf_pkg::KIND_PUB, 8'd0, 1'b1);
                end
            end
            tbpf_pkg::ACT_TICK: begin
                if (mode_enable) begin
                    len = frame_len[active_buf];
                    gen = frame_gen[active_buf];
                    if (len == 0 || cmd.busy || (!mode_repeat && gen == last_sent_gen)) begin
                        skip_count++;
                        push_result(tbpf_pkg::KIND_SKIP, 8'd0, 1'b1);
                    end else begin
                        sent_tally++;
                        if (!mode_repeat) last_sent_gen = gen;
                        for (int i = 0; i < len; i++) begin
                            push_result(tbpf_pkg::KIND_BYTE,
                                        frame_bytes[active_buf*tbpf_pkg::FRAME_BYTES + i],
                                        i == len - 1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // monitor: predict on input beats, check result beats
    always @(posedge i_clk) begin
        t_frame_result exp;
        in_beat  <= in_valid && o_in_ready;
        cfg_beat <= cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (tx_results_due.size() == 0) begin
                    note_mismatch($sformatf("result beat kind %0d with nothing due", o_kind));
                end else begin
                    exp = tx_results_due.pop_front();
                    if (o_kind !== exp.kind)
                        note_mismatch($sformatf("kind %0d, want %0d", o_kind, exp.kind));
                    if (o_tx_byte !== exp.tx_byte)
                        note_mismatch($sformatf("tx_byte %0h, want %0h", o_tx_byte,
                                                exp.tx_byte));
                    if (o_last !== exp.last)
                        note_mismatch($sformatf("last %0b, want %0b", o_last, exp.last));
                    if (o_sent_total !== exp.sent)
                        note_mismatch($sformatf("sent_total %0d, want %0d", o_sent_total,
                                                exp.sent));
                    if (o_skipped_total !== exp.skipped)
                        note_mismatch($sformatf("skipped_total %0d, want %0d",
                                                o_skipped_total, exp.skipped));
                end
            end
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    tbpf_pkg::CFG_REPEAT_MODE: mode_repeat = cfg_data;
                    tbpf_pkg::CFG_ENABLE:      mode_enable = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_valid && o_in_ready) apply_frame_cmd('{in_action, in_data, in_busy});
        end
    end

    // sender: hold payload until the beat, then advance
    always @(negedge i_clk) begin
        t_frame_cmd cmd;
        if (!in_valid || in_beat) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                cmd = cmd_queue.pop_front();
                in_valid  <= 1'b1;
                in_action <= cmd.action;
                in_data   <= cmd.data;
                in_busy   <= cmd.busy;
                gap_left  = calm_src ? 0 : pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus requested long holds
    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack   = hold_req;
            stall_left = SINK_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!calm_sink && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("triple_buffered_periodic_frame_tx: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [tbpf_pkg::CFG_IDX_W-1:0] idx, input logic val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_beat);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(input logic [1:0] act, input logic [7:0] data, input logic busy);
        cmd_queue.push_back('{act, data, busy});
        items_counted++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || in_valid || tx_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_frame(input int len, input int ticks);
        for (int i = 0; i < len; i++) push_cmd(tbpf_pkg::ACT_LOAD, 8'($urandom), 1'b0);
        push_cmd(tbpf_pkg::ACT_PUBLISH, 8'($urandom), 1'($urandom));
        for (int i = 0; i < ticks; i++) push_cmd(tbpf_pkg::ACT_TICK, 8'($urandom),
                                                 $urandom_range(0, 7) == 0);
    endtask

    task automatic queue_random_traffic(input int budget);
        int target;
        int r;
        int len;
        target = items_counted + budget;
        while (items_counted < target) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                push_cmd(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            end else if (r < 20) begin
                // drop the publish: loads roll into the next frame
                repeat ($urandom_range(1, 5))
                    push_cmd(tbpf_pkg::ACT_LOAD, 8'($urandom), 1'b0);
                push_cmd(tbpf_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)      len = $urandom_range(0, 8);
                else if (r < 85) len = $urandom_range(9, 40);
                else if (r < 93) len = tbpf_pkg::FRAME_BYTES;
                else             len = $urandom_range(tbpf_pkg::FRAME_BYTES + 1,
                                                      tbpf_pkg::FRAME_BYTES + 4);
                queue_frame(len, $urandom_range(1, 3));
            end
        end
    endtask

    initial begin
        bit rep_plan[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        bit en_plan[PHASES]  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // disabled: ticks and the unused code do nothing
        push_cmd(tbpf_pkg::ACT_TICK, 8'h00, 1'b0);
        push_cmd(ACT_UNUSED, 8'hFF, 1'b1);
        push_cmd(tbpf_pkg::ACT_LOAD, 8'h00, 1'b0);
        push_cmd(tbpf_pkg::ACT_LOAD, 8'hFF, 1'b0);
        push_cmd(tbpf_pkg::ACT_PUBLISH, 8'h00, 1'b0);
        wait_idle();

        write_reg(tbpf_pkg::CFG_ENABLE, 1'b1);
        @(posedge i_clk);
        push_cmd(tbpf_pkg::ACT_TICK, 8'h00, 1'b0);
        push_cmd(tbpf_pkg::ACT_TICK, 8'h00, 1'b1);
        push_cmd(tbpf_pkg::ACT_TICK, 8'hFF, 1'b0);
        push_cmd(tbpf_pkg::ACT_PUBLISH, 8'h00, 1'b0);
        push_cmd(tbpf_pkg::ACT_TICK, 8'h00, 1'b0);
        push_cmd(tbpf_pkg::ACT_LOAD, 8'h5A, 1'b0);
        push_cmd(tbpf_pkg::ACT_PUBLISH, 8'h00, 1'b0);
        wait_idle();

        // one-shot: second tick on the same generation skips
        write_reg(tbpf_pkg::CFG_REPEAT_MODE, 1'b0);
        @(posedge i_clk);
        push_cmd(tbpf_pkg::ACT_TICK, 8'h00, 1'b0);
        push_cmd(tbpf_pkg::ACT_TICK, 8'h00, 1'b0);
        push_cmd(tbpf_pkg::ACT_LOAD, 8'hA5, 1'b0);
        push_cmd(tbpf_pkg::ACT_LOAD, 8'h3C, 1'b0);
        push_cmd(tbpf_pkg::ACT_PUBLISH, 8'h00, 1'b0);
        push_cmd(tbpf_pkg::ACT_TICK, 8'h00, 1'b1);
        push_cmd(tbpf_pkg::ACT_TICK, 8'h00, 1'b0);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(tbpf_pkg::CFG_REPEAT_MODE, rep_plan[p]);
            write_reg(tbpf_pkg::CFG_ENABLE, en_plan[p]);
            @(posedge i_clk);
            calm_src  = (p == 2) || (p == 5);
            calm_sink = (p == 4);
            if (p == 0) begin
                queue_frame(tbpf_pkg::FRAME_BYTES, 2);
                queue_frame(tbpf_pkg::FRAME_BYTES + 2, 1);
            end
            if (p == 2) begin
                hold_req++;
                queue_frame($urandom_range(20, tbpf_pkg::FRAME_BYTES), 3);
            end
            queue_random_traffic(22);
            wait_idle();
        end

        calm_src  = 1'b0;
        calm_sink = 1'b0;
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("triple_buffered_periodic_frame_tx: match");
        end else begin
            $display("triple_buffered_periodic_frame_tx: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/tbpf_pkg.sv
rtl/tbpf_ram.sv
rtl/triple_buffered_periodic_frame_tx.sv
test/triple_buffered_periodic_frame_tx_test.sv
